@@ hdl/gbl_pkg.sv @@
// Shared constants, types and gap tables for the SNR-gap bit loader.
package gbl_pkg;

	// Symbol geometry and constellation limits
	localparam int CARRIER_LIMIT = 1024;
	localparam int MAX_BITS      = 10;
	localparam int BITS_W        = $clog2(MAX_BITS + 1);
	localparam int TOTAL_W       = 14;
	localparam int RAW_CAP       = CARRIER_LIMIT * MAX_BITS;
	localparam int CAP_INT       = (RAW_CAP > 16383) ? 16383 : RAW_CAP;
	localparam logic [TOTAL_W-1:0] TOTAL_CAP = TOTAL_W'(CAP_INT);

	// Fixed-point widths: SNR Q20.12, gap Q2.16, thresholds gap*(2^k-1)
	localparam int SNR_W  = 32;
	localparam int CMP_W  = SNR_W + 4;
	localparam int GAP_W  = 18;
	localparam int THR_W  = GAP_W + MAX_BITS;
	localparam int RATE_W = 3;

	// FEC rate codes
	localparam logic [RATE_W-1:0] RATE_HALF          = 3'd0;
	localparam logic [RATE_W-1:0] RATE_FIVE_EIGHTHS  = 3'd1;
	localparam logic [RATE_W-1:0] RATE_THREE_QTR     = 3'd2;
	localparam logic [RATE_W-1:0] RATE_SEVEN_EIGHTHS = 3'd3;
	localparam logic [RATE_W-1:0] RATE_OTHER         = 3'd4;
	localparam logic [RATE_W-1:0] RATE_RESET         = RATE_HALF;

	typedef logic [MAX_BITS-1:0][THR_W-1:0] thr_vec_t;

	// Result of the compare stage, handed to the accumulator
	typedef struct packed {
		logic [BITS_W-1:0] bits;
		logic              last;
	} calc_t;

	// Linear gap 10^(dB/10) in Q2.16
	function automatic logic [GAP_W-1:0] gap_q16(input logic [RATE_W-1:0] sel);
		logic [GAP_W-1:0] g;
		case (sel)
			RATE_HALF:          g = GAP_W'(103868);
			RATE_FIVE_EIGHTHS:  g = GAP_W'(116541);
			RATE_THREE_QTR:     g = GAP_W'(146717);
			RATE_SEVEN_EIGHTHS: g = GAP_W'(207243);
			default:            g = GAP_W'(130762);
		endcase
		return g;
	endfunction

	// Threshold k (entry k-1) is gap*(2^k - 1) = (gap << k) - gap
	function automatic thr_vec_t thr_for_rate(input logic [RATE_W-1:0] sel);
		thr_vec_t         t;
		logic [THR_W-1:0] g;
		g = THR_W'(gap_q16(sel));
		for (int k = 1; k <= MAX_BITS; k++) begin
			t[k-1] = (g << k) - g;
		end
		return t;
	endfunction

endpackage

@@ hdl/ofdm_gap_bit_loader.sv @@
// Top level of the per-carrier SNR-gap bit loader.
// Usage:
//   Input channel (in_valid/in_ready): one beat per subcarrier with snr_linear
//   (unsigned Q20.12), snr_invalid and last_carrier.
//   Output channel (out_valid/out_ready): one beat per input beat with
//   carrier_bits (0,1,2,4,6,8,10), running_total of the symbol so far, and
//   end_of_map copied from last_carrier. The total restarts after that beat.
//   Config channel (cfg_valid/cfg_ready/rate_select): FEC rate code; the user
//   must offer it to be taken only while no carrier is in flight, which the
//   block itself does not enforce; cfg_ready is always high.
// Pipeline: input register, compare and add, result register.
// Throughput: one carrier per cycle while out_ready stays high; the ten
//   threshold compares and the total add each fit between a pair of registers.
// Reset: pipeline empties, total clears, rate code returns to rate 1/2.
// Receiver stall: the result register holds; the input register fills, and
//   in_ready drops only once both stages hold beats.
module ofdm_gap_bit_loader (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [gbl_pkg::RATE_W-1:0]    rate_select,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [gbl_pkg::SNR_W-1:0]     snr_linear,
	input  logic                          snr_invalid,
	input  logic                          last_carrier,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [gbl_pkg::BITS_W-1:0]    carrier_bits,
	output logic [gbl_pkg::TOTAL_W-1:0]   running_total,
	output logic                          end_of_map
);

	gbl_pkg::thr_vec_t thr;
	gbl_pkg::calc_t    calc;
	logic              calc_valid;
	logic              calc_ready;

	gbl_thr_regs u_thr_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.rate_select (rate_select),
		.thr         (thr)
	);

	gbl_bit_calc u_bit_calc (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.snr_linear   (snr_linear),
		.snr_invalid  (snr_invalid),
		.last_carrier (last_carrier),
		.thr          (thr),
		.calc_valid   (calc_valid),
		.calc_ready   (calc_ready),
		.calc         (calc)
	);

	gbl_accum u_accum (
		.clk           (clk),
		.arst_n        (arst_n),
		.calc_valid    (calc_valid),
		.calc_ready    (calc_ready),
		.calc          (calc),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.carrier_bits  (carrier_bits),
		.running_total (running_total),
		.end_of_map    (end_of_map)
	);

	// A ready receiver never backs up the input side
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while receiver ready");

	// Only valid constellation orders leave the block
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((carrier_bits <= gbl_pkg::BITS_W'(1)) || !carrier_bits[0]) &&
			(carrier_bits <= gbl_pkg::BITS_W'(gbl_pkg::MAX_BITS)))
		else $error("invalid carrier bit count");

	// Total includes this carrier and stays within the symbol capacity
	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (running_total >= gbl_pkg::TOTAL_W'(carrier_bits)) &&
			(running_total <= gbl_pkg::TOTAL_CAP))
		else $error("running total out of range");

endmodule

@@ hdl/gbl_thr_regs.sv @@
// Configuration register: holds the threshold set of the selected FEC rate.
module gbl_thr_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [gbl_pkg::RATE_W-1:0]    rate_select,
	output gbl_pkg::thr_vec_t             thr
);

	gbl_pkg::thr_vec_t thr_q;

	assign cfg_ready = 1'b1;
	assign thr       = thr_q;

	// Thresholds are expanded once at write time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= gbl_pkg::thr_for_rate(gbl_pkg::RATE_RESET);
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= gbl_pkg::thr_for_rate(rate_select);
		end
	end

endmodule

@@ hdl/gbl_bit_calc.sv @@
// Input register and threshold compare: gives the constellation order of one carrier.
module gbl_bit_calc (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [gbl_pkg::SNR_W-1:0]   snr_linear,
	input  logic                        snr_invalid,
	input  logic                        last_carrier,
	input  gbl_pkg::thr_vec_t           thr,
	output logic                        calc_valid,
	input  logic                        calc_ready,
	output gbl_pkg::calc_t              calc
);

	logic                       v_s1;
	logic [gbl_pkg::SNR_W-1:0]  snr_s1;
	logic                       inv_s1;
	logic                       last_s1;

	logic [gbl_pkg::CMP_W-1:0]  snr_cmp;
	logic [gbl_pkg::BITS_W-1:0] thr_hits;
	logic [gbl_pkg::BITS_W-1:0] ord_bits;

	assign in_ready   = !v_s1 || calc_ready;
	assign calc_valid = v_s1;

	// Stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			snr_s1  <= snr_linear;
			inv_s1  <= snr_invalid;
			last_s1 <= last_carrier;
		end
	end

	// SNR in Q.16; thresholds rise with k, so the highest one met sets b
	always_comb begin
		snr_cmp  = {snr_s1, 4'b0000};
		thr_hits = '0;
		for (int k = 1; k <= gbl_pkg::MAX_BITS; k++) begin
			if (snr_cmp >= gbl_pkg::CMP_W'(thr[k-1])) begin
				thr_hits = gbl_pkg::BITS_W'(k);
			end
		end
	end

	// Odd orders above one drop to the next lower even order; bad SNR loads nothing
	always_comb begin
		if (inv_s1 || (snr_s1 == '0)) begin
			ord_bits = '0;
		end else if (thr_hits <= gbl_pkg::BITS_W'(1)) begin
			ord_bits = thr_hits;
		end else begin
			ord_bits = {thr_hits[gbl_pkg::BITS_W-1:1], 1'b0};
		end
	end

	assign calc.bits = ord_bits;
	assign calc.last = last_s1;

endmodule

@@ hdl/gbl_accum.sv @@
// Result register and per-symbol running total of loaded bits.
module gbl_accum (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         calc_valid,
	output logic                         calc_ready,
	input  gbl_pkg::calc_t               calc,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [gbl_pkg::BITS_W-1:0]   carrier_bits,
	output logic [gbl_pkg::TOTAL_W-1:0]  running_total,
	output logic                         end_of_map
);

	logic                         v_s2;
	logic [gbl_pkg::BITS_W-1:0]   bits_s2;
	logic [gbl_pkg::TOTAL_W-1:0]  total_s2;
	logic                         last_s2;
	logic [gbl_pkg::TOTAL_W-1:0]  acc_q;

	logic [gbl_pkg::TOTAL_W:0]    sum;
	logic [gbl_pkg::TOTAL_W-1:0]  total;
	logic                         take;

	assign calc_ready = !v_s2 || out_ready;
	assign take       = calc_valid && calc_ready;

	// Add with saturation at the symbol capacity
	always_comb begin
		sum = {1'b0, acc_q} + (gbl_pkg::TOTAL_W + 1)'(calc.bits);
		if (sum > {1'b0, gbl_pkg::TOTAL_CAP}) begin
			total = gbl_pkg::TOTAL_CAP;
		end else begin
			total = sum[gbl_pkg::TOTAL_W-1:0];
		end
	end

	// Output valid and accumulator; total restarts after the last carrier
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2  <= 1'b0;
			acc_q <= '0;
		end else begin
			if (calc_ready) begin
				v_s2 <= calc_valid;
			end
			if (take) begin
				acc_q <= calc.last ? '0 : total;
			end
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (take) begin
			bits_s2  <= calc.bits;
			total_s2 <= total;
			last_s2  <= calc.last;
		end
	end

	assign out_valid     = v_s2;
	assign carrier_bits  = bits_s2;
	assign running_total = total_s2;
	assign end_of_map    = last_s2;

endmodule

@@ bench/tb_ofdm_gap_bit_loader.sv @@
// Self-checking testbench for the SNR-gap bit loader: directed edges, rate sweep, cap, random, steady stream.
module tb_ofdm_gap_bit_loader;

	localparam int HALF_PERIOD = 2;
	localparam int RUN_LIMIT   = 2_000_000;
	// Symbol total saturates here
	localparam int TOTAL_LIMIT =
		(gbl_pkg::CARRIER_LIMIT * gbl_pkg::MAX_BITS > 16383) ? 16383
		: gbl_pkg::CARRIER_LIMIT * gbl_pkg::MAX_BITS;

	// Rate codes past the defined ones all fall back to the 3 dB gap
	localparam logic [gbl_pkg::RATE_W-1:0] RATE_SPARE_LO  = 3'd5;
	localparam logic [gbl_pkg::RATE_W-1:0] RATE_SPARE_MID = 3'd6;
	localparam logic [gbl_pkg::RATE_W-1:0] RATE_SPARE_HI  = 3'd7;

	typedef struct packed {
		logic [gbl_pkg::BITS_W-1:0]  bits;
		logic [gbl_pkg::TOTAL_W-1:0] total;
		logic                        closes;
	} carrier_load_t;

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         cfg_valid;
	logic                         cfg_ready;
	logic [gbl_pkg::RATE_W-1:0]   rate_select;
	logic                         in_valid;
	logic                         in_ready;
	logic [gbl_pkg::SNR_W-1:0]    snr_linear;
	logic                         snr_invalid;
	logic                         last_carrier;
	logic                         out_valid;
	logic                         out_ready;
	logic [gbl_pkg::BITS_W-1:0]   carrier_bits;
	logic [gbl_pkg::TOTAL_W-1:0]  running_total;
	logic                         end_of_map;

	// Shadow state of the loader
	logic [gbl_pkg::RATE_W-1:0]   rate_model;
	int                           symbol_sum;
	carrier_load_t                pending_loads[$];

	// Run bookkeeping
	int                           idle_pct;
	int                           stall_left;
	int                           fail_count;
	int                           loads_checked;
	int                           rate_writes;
	int                           maps_closed;
	int                           cap_hits;

	ofdm_gap_bit_loader i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.rate_select  (rate_select),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.snr_linear   (snr_linear),
		.snr_invalid  (snr_invalid),
		.last_carrier (last_carrier),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.carrier_bits (carrier_bits),
		.running_total(running_total),
		.end_of_map   (end_of_map)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// Linear gap in Q2.16 for a rate code
	function automatic longint unsigned gap_for(input logic [gbl_pkg::RATE_W-1:0] code);
		case (code)
			gbl_pkg::RATE_HALF:          return 103868;
			gbl_pkg::RATE_FIVE_EIGHTHS:  return 116541;
			gbl_pkg::RATE_THREE_QTR:     return 146717;
			gbl_pkg::RATE_SEVEN_EIGHTHS: return 207243;
			default:                     return 130762;
		endcase
	endfunction

	// Smallest SNR that meets threshold k: ceil(gap*(2^k-1)/16)
	function automatic logic [gbl_pkg::SNR_W-1:0] snr_edge(
			input logic [gbl_pkg::RATE_W-1:0] code, input int k);
		longint unsigned thr;
		thr = gap_for(code) * ((64'd1 << k) - 64'd1);
		return gbl_pkg::SNR_W'((thr + 64'd15) / 64'd16);
	endfunction

	// Bits loaded on one carrier: threshold count, then even order above 1
	function automatic logic [gbl_pkg::BITS_W-1:0] predict_load(
			input logic [gbl_pkg::SNR_W-1:0] snr,
			input logic bad, input logic [gbl_pkg::RATE_W-1:0] code);
		longint unsigned scaled;
		longint unsigned gap;
		int              raw;
		raw    = 0;
		gap    = gap_for(code);
		scaled = {28'd0, snr, 4'd0};
		if (bad || snr == '0)
			return '0;
		for (int k = 1; k <= gbl_pkg::MAX_BITS; k++) begin
			if (scaled >= gap * ((64'd1 << k) - 64'd1))
				raw = k;
		end
		if (raw > 1)
			raw = raw & ~1;
		return gbl_pkg::BITS_W'(raw);
	endfunction

	// SNR mix: threshold neighbors, log-spread, full range, zero
	function automatic logic [gbl_pkg::SNR_W-1:0] draw_snr(
			input logic [gbl_pkg::RATE_W-1:0] code);
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 4)
			return snr_edge(code, $urandom_range(1, gbl_pkg::MAX_BITS)) - 32'd1
				+ 32'($urandom_range(0, 2));
		else if (pick < 8)
			return $urandom >> $urandom_range(0, 31);
		else if (pick == 8)
			return $urandom;
		return '0;
	endfunction

	// Monitor: check result beats, then predict accepted carrier beats
	always @(posedge clk) begin : watch
		carrier_load_t want;
		carrier_load_t got;
		int            sum;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got = '{carrier_bits, running_total, end_of_map};
				if (pending_loads.size() == 0) begin
					$error("result beat with nothing expected: bits %0d total %0d",
						got.bits, got.total);
					fail_count++;
				end else begin
					want = pending_loads.pop_front();
					loads_checked++;
					if (got.bits !== want.bits) begin
						$error("carrier_bits: expected %0d, got %0d", want.bits, got.bits);
						fail_count++;
					end
					if (got.total !== want.total) begin
						$error("running_total: expected %0d, got %0d", want.total, got.total);
						fail_count++;
					end
					if (got.closes !== want.closes) begin
						$error("end_of_map: expected %0d, got %0d", want.closes, got.closes);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				want.bits = predict_load(snr_linear, snr_invalid, rate_model);
				sum = symbol_sum + want.bits;
				if (sum > TOTAL_LIMIT) begin
					sum = TOTAL_LIMIT;
					cap_hits++;
				end
				want.total  = gbl_pkg::TOTAL_W'(sum);
				want.closes = last_carrier;
				pending_loads.insert(pending_loads.size(), want);
				symbol_sum = last_carrier ? 0 : sum;
				if (last_carrier)
					maps_closed++;
			end
			if (cfg_valid && cfg_ready) begin
				rate_model = rate_select;
				rate_writes++;
			end
		end
	end

	// Receiver: stalls in random bursts, never when idle_pct is zero
	always @(negedge clk) begin
		if (idle_pct == 0) begin
			stall_left = 0;
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if ($urandom_range(0, 99) < idle_pct) begin
			stall_left = $urandom_range(1, 10) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// One carrier beat; entered and left at a falling edge, valid left high
	task automatic send_carrier(input logic [gbl_pkg::SNR_W-1:0] snr, input logic bad,
			input logic fin);
		int hold;
		if ($urandom_range(0, 99) < idle_pct) begin
			hold = $urandom_range(1, 10);
			in_valid     <= 1'b0;
			snr_linear   <= $urandom;
			snr_invalid  <= 1'($urandom_range(0, 1));
			last_carrier <= 1'($urandom_range(0, 1));
			repeat (hold) @(negedge clk);
		end
		in_valid     <= 1'b1;
		snr_linear   <= snr;
		snr_invalid  <= bad;
		last_carrier <= fin;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic stop_input();
		in_valid <= 1'b0;
	endtask

	// Rate change only once every pending result has come out
	task automatic write_rate(input logic [gbl_pkg::RATE_W-1:0] code);
		stop_input();
		while (pending_loads.size() != 0)
			@(negedge clk);
		cfg_valid   <= 1'b1;
		rate_select <= code;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid   <= 1'b0;
		rate_select <= gbl_pkg::RATE_W'($urandom_range(0, 7));
	endtask

	// Random symbols, mostly short, now and then long
	task automatic run_symbols(input int count);
		int left;
		left = 0;
		for (int n = 0; n < count; n++) begin
			if (left == 0)
				left = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 200)
				                                   : $urandom_range(1, 40);
			left--;
			send_carrier(draw_snr(rate_model), $urandom_range(0, 11) == 0, left == 0);
		end
	endtask

	// Reset rate (1/2): zero, invalid, full scale, and every threshold edge
	task automatic test_reset_edges();
		idle_pct = 20;
		send_carrier('0, 1'b0, 1'b0);
		send_carrier('0, 1'b1, 1'b0);
		send_carrier('1, 1'b0, 1'b0);
		send_carrier('1, 1'b1, 1'b1);
		send_carrier(snr_edge(gbl_pkg::RATE_HALF, 1) - 32'd1, 1'b0, 1'b0);
		for (int k = 1; k <= gbl_pkg::MAX_BITS; k++)
			send_carrier(snr_edge(gbl_pkg::RATE_HALF, k), 1'b0, 1'b0);
		send_carrier(snr_edge(gbl_pkg::RATE_HALF, gbl_pkg::MAX_BITS) - 32'd1, 1'b0, 1'b0);
		send_carrier('1, 1'b0, 1'b1);
	endtask

	// Every rate code, spare codes included, with random symbols
	task automatic test_rate_sweep();
		logic [gbl_pkg::RATE_W-1:0] codes[8];
		codes = '{RATE_SPARE_HI, gbl_pkg::RATE_HALF, gbl_pkg::RATE_FIVE_EIGHTHS,
		          gbl_pkg::RATE_THREE_QTR, gbl_pkg::RATE_SEVEN_EIGHTHS,
		          gbl_pkg::RATE_OTHER, RATE_SPARE_LO, RATE_SPARE_MID};
		foreach (codes[i]) begin
			write_rate(codes[i]);
			idle_pct = $urandom_range(0, 3) * 10;
			run_symbols(8);
		end
	endtask

	// Long symbol of high-SNR carriers drives the total into its cap
	task automatic test_total_cap();
		write_rate(gbl_pkg::RATE_SEVEN_EIGHTHS);
		idle_pct = 10;
		send_carrier(draw_snr(rate_model), 1'b0, 1'b1);
		for (int n = 0; n < gbl_pkg::CARRIER_LIMIT + 2; n++)
			send_carrier($urandom_range(32'h0100_0000, 32'hFFFF_FFFF), 1'b0, 1'b0);
		send_carrier('0, 1'b0, 1'b0);
		send_carrier('1, 1'b1, 1'b0);
		send_carrier('1, 1'b0, 1'b0);
		send_carrier('1, 1'b0, 1'b1);
	endtask

	// Random rate changes between chunks of random symbols
	task automatic test_random_mix();
		repeat (3) begin
			write_rate(gbl_pkg::RATE_W'($urandom_range(0, 7)));
			idle_pct = $urandom_range(0, 4) * 10;
			run_symbols($urandom_range(5, 15));
		end
	endtask

	// Closing stretch at full rate, no idling on either side
	task automatic test_steady_stream();
		write_rate(gbl_pkg::RATE_W'($urandom_range(0, 7)));
		idle_pct = 0;
		run_symbols(30);
	endtask

	initial begin
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		rate_select  = '0;
		in_valid     = 1'b0;
		snr_linear   = '0;
		snr_invalid  = 1'b0;
		last_carrier = 1'b0;
		out_ready    = 1'b0;
		rate_model   = gbl_pkg::RATE_RESET;
		symbol_sum   = 0;
		idle_pct     = 0;
		stall_left   = 0;
		fail_count   = 0;
		loads_checked = 0;
		rate_writes  = 0;
		maps_closed  = 0;
		cap_hits     = 0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_edges();
		test_rate_sweep();
		test_total_cap();
		test_random_mix();
		test_steady_stream();

		// Drain, then wait with no input to catch stray beats
		stop_input();
		while (pending_loads.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);

		$display("Checked %0d carrier loads over %0d rate writes and %0d closed tone maps,",
			loads_checked, rate_writes, maps_closed);
		$display("with the symbol total held at its cap on %0d carriers.", cap_hits);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin : watchdog
		#(RUN_LIMIT);
		$display("FAIL");
		$finish;
	end

endmodule
